[src/assert_macros.svh]
// Assertion macros used by the checker in rmst_checker.sv.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("check failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

[src/rmst_pkg.sv]
package rmst_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int NODE_CNT     = 2 * MAX_ELEMENTS;
    localparam int NODE_AW      = $clog2(NODE_CNT);
    localparam int IDX_W        = 11;
    localparam int VAL_W        = 32;
    localparam int EXT_W        = ((NODE_AW > IDX_W) ? NODE_AW : IDX_W) + 1;
    localparam int IN_DATA_W    = ((2 * IDX_W + VAL_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] COUNT_RST = IDX_W'(1024);
    localparam logic [VAL_W-1:0] SIGN_BIT  = {1'b1, {(VAL_W - 1){1'b0}}};

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef logic [VAL_W-1:0] key_t;
    typedef logic [EXT_W-1:0] ext_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic upd_rd;
        logic upd_wr;
        logic qry_rd;
        logic qry_acc;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic p_le_one;
        logic l_lt_r;
        logic out_free;
    } dp_stat_t;

endpackage

[src/rmst_ctrl.sv]
module rmst_ctrl
    import rmst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_cmd,
    input  dp_stat_t stat,
    output logic     in_ready,
    output dp_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_U_RD   = 3'd2;
    localparam logic [2:0] ST_U_WR   = 3'd3;
    localparam logic [2:0] ST_Q_RD   = 3'd4;
    localparam logic [2:0] ST_Q_ACC  = 3'd5;
    localparam logic [2:0] ST_Q_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_cmd == CMD_QUERY) ? ST_Q_RD : ST_U_RD;
                end
            end
            ST_U_RD:
            begin
                if (stat.p_le_one)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.upd_rd = 1'b1;
                    state_next = ST_U_WR;
                end
            end
            ST_U_WR:
            begin
                cmd.upd_wr = 1'b1;
                state_next = ST_U_RD;
            end
            ST_Q_RD:
            begin
                cmd.qry_rd = 1'b1;
                state_next = stat.l_lt_r ? ST_Q_ACC : ST_Q_DONE;
            end
            ST_Q_ACC:
            begin
                cmd.qry_acc = 1'b1;
                state_next  = ST_Q_RD;
            end
            ST_Q_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/rmst_dpath.sv]
module rmst_dpath
    import rmst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  logic             in_cmd,
    input  logic [IDX_W-1:0] first_index,
    input  logic [IDX_W-1:0] last_index,
    input  logic [VAL_W-1:0] new_value,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_wr_data,
    input  logic             out_ready,
    output dp_stat_t         stat,
    output logic             out_valid,
    output logic [VAL_W-1:0] out_data
);

    key_t               mem [NODE_CNT];
    key_t               rd_a_reg;
    key_t               rd_b_reg;

    logic [IDX_W-1:0]   count_reg;
    logic [NODE_AW-1:0] clr_cnt_reg;
    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_data_reg;

    ext_t               l_reg;
    ext_t               l_next;
    ext_t               r_reg;
    ext_t               r_next;
    key_t               acc_reg;
    key_t               acc_next;
    key_t               pair_reg;
    key_t               pair_next;

    ext_t               eff_n;
    ext_t               fi;
    ext_t               li;
    ext_t               lo;
    ext_t               hi;
    ext_t               leaf_l;
    ext_t               leaf_r;
    ext_t               sib;
    ext_t               r_m1;
    ext_t               parent;
    logic               upd_ok;
    logic               q_empty;

    key_t               in_key;
    key_t               upd_max;
    key_t               a_m;
    key_t               b_m;

    logic               wr_en;
    logic [NODE_AW-1:0] wr_addr;
    key_t               wr_data;
    logic [NODE_AW-1:0] rd_a_addr;
    logic [NODE_AW-1:0] rd_b_addr;

    // The tree stores each value with its sign bit flipped, so an unsigned
    // compare orders the keys and the smallest value is all zeros.
    always_comb
    begin
        eff_n   = (ext_t'(count_reg) > ext_t'(MAX_ELEMENTS)) ? ext_t'(MAX_ELEMENTS)
                                                             : ext_t'(count_reg);
        fi      = ext_t'(first_index);
        li      = ext_t'(last_index);
        upd_ok  = (fi != '0) && (fi <= eff_n);
        lo      = (fi == '0) ? ext_t'(1) : fi;
        hi      = (li > eff_n) ? eff_n : li;
        q_empty = lo > hi;
        leaf_l  = ext_t'(MAX_ELEMENTS) + lo - ext_t'(1);
        leaf_r  = ext_t'(MAX_ELEMENTS) + hi;
        in_key  = new_value ^ SIGN_BIT;
        sib     = l_reg ^ ext_t'(1);
        r_m1    = r_reg - ext_t'(1);
        parent  = l_reg >> 1;
        upd_max = (rd_a_reg > acc_reg) ? rd_a_reg : acc_reg;
        a_m     = l_reg[0] ? rd_a_reg : '0;
        b_m     = r_reg[0] ? rd_b_reg : '0;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = '0;
        if (cmd.clr_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.load && (in_cmd == CMD_UPDATE) && upd_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = leaf_l[NODE_AW-1:0];
            wr_data = in_key;
        end
        else if (cmd.upd_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = parent[NODE_AW-1:0];
            wr_data = upd_max;
        end
        rd_a_addr = cmd.upd_rd ? sib[NODE_AW-1:0] : l_reg[NODE_AW-1:0];
        rd_b_addr = r_m1[NODE_AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_comb
    begin
        l_next    = l_reg;
        r_next    = r_reg;
        acc_next  = acc_reg;
        pair_next = pair_reg;
        if (cmd.load)
        begin
            pair_next = '0;
            if (in_cmd == CMD_QUERY)
            begin
                l_next   = q_empty ? '0 : leaf_l;
                r_next   = q_empty ? '0 : leaf_r;
                acc_next = '0;
            end
            else
            begin
                l_next   = upd_ok ? leaf_l : ext_t'(1);
                acc_next = in_key;
            end
        end
        else if (cmd.upd_wr)
        begin
            l_next   = parent;
            acc_next = upd_max;
        end
        else if (cmd.qry_rd)
        begin
            acc_next = (pair_reg > acc_reg) ? pair_reg : acc_reg;
        end
        else if (cmd.qry_acc)
        begin
            pair_next = (a_m > b_m) ? a_m : b_m;
            l_next    = (l_reg + ext_t'(l_reg[0])) >> 1;
            r_next    = r_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg    <= l_next;
        r_reg    <= r_next;
        acc_reg  <= acc_next;
        pair_reg <= pair_next;
        if (cmd.out_load)
        begin
            out_data_reg <= acc_reg ^ SIGN_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RST;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + NODE_AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clr_last = (clr_cnt_reg == NODE_AW'(NODE_CNT - 1));
    assign stat.p_le_one = (l_reg <= ext_t'(1));
    assign stat.l_lt_r   = (l_reg < r_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[src/range_max_segment_tree_core.sv]
// Channel   Direction  Beat contents
// s_axis    in         tuser: command; tdata: first_index, last_index, new_value
// m_axis    out        tdata: range_maximum
// cfg       in         cfg_wr_data: element_count, written when cfg_wr_en is high
//
// An update climbs the tree from its leaf, one level per read state and write state through the
// node memory; a query moves both range ends upward, one level per read state and accumulate state.
// After reset the node memory is cleared one node a cycle, every node, before s_axis is ready.
// A finished query waits in the output register; new beats are taken while it waits.
// A stalled m_axis holds the next query in its last cycle until the output register frees.
module range_max_segment_tree_core
    import rmst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // first_index [10:0], last_index [21:11], new_value [53:22], zero pad above
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // command [0]
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // range_maximum [31:0]
    output logic [VAL_W-1:0]     m_axis_tdata,
    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_wr_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rmst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_cmd   (s_axis_tuser[0]),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    rmst_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_cmd      (s_axis_tuser[0]),
        .first_index (s_axis_tdata[IDX_W-1:0]),
        .last_index  (s_axis_tdata[2*IDX_W-1:IDX_W]),
        .new_value   (s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (m_axis_tready),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_data    (m_axis_tdata)
    );

endmodule

[src/rmst_checker.sv]
`include "assert_macros.svh"

module rmst_checker
    import rmst_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [0:0]           s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [VAL_W-1:0]     m_axis_tdata
);

    logic in_beat;
    logic upd_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign upd_beat = in_beat && (s_axis_tuser[0] == CMD_UPDATE);

    // A stalled result keeps its data.
    `CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Only one beat is in work at a time.
    `CHK_NEXT(a_one_in_work, in_beat, !s_axis_tready)

    // A result appears only after work, never straight out of the idle state.
    `CHK_SAME(a_out_after_work, $rose(m_axis_tvalid), $past(!s_axis_tready))

    // An update beat never produces a result on its own.
    `CHK_NEXT(a_upd_silent, upd_beat && !m_axis_tvalid, !m_axis_tvalid)

endmodule

bind range_max_segment_tree_core rmst_checker u_rmst_checker (.*);

[bench/range_max_checker.sv]
`timescale 1ns / 1ps

module range_max_checker
    import rmst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [0:0]           s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [VAL_W-1:0]     m_axis_tdata,
    input  logic                 cfg_wr_en,
    input  logic [IDX_W-1:0]     cfg_wr_data,
    output int                   mismatch_count,
    output int                   maxima_pending,
    output int                   maxima_checked
);

    key_t             element_values [1:MAX_ELEMENTS];
    logic [IDX_W-1:0] element_count = COUNT_RST;
    key_t             expected_maxima [$];
    int               errors = 0;
    int               checked = 0;

    function automatic int count_in_use();
        return (element_count > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(element_count);
    endfunction

    // Element values are kept flat; the maximum is taken over the clipped range.
    function automatic key_t clipped_range_max(logic [IDX_W-1:0] lo_idx,
                                               logic [IDX_W-1:0] hi_idx);
        int   lo;
        int   hi;
        key_t best;
        lo = (lo_idx < 1) ? 1 : int'(lo_idx);
        hi = (hi_idx > count_in_use()) ? count_in_use() : int'(hi_idx);
        best = SIGN_BIT;
        for (int i = lo; i <= hi; i++)
        begin
            if ($signed(element_values[i]) > $signed(best))
                best = element_values[i];
        end
        return best;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: MISMATCH: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
        key_t             value;
        key_t             want;
        if (!rst_n)
        begin
            for (int i = 1; i <= MAX_ELEMENTS; i++)
                element_values[i] = SIGN_BIT;
            element_count = COUNT_RST;
            expected_maxima.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_maxima.size() == 0)
                    report_mismatch($sformatf("maximum %0d with no query waiting",
                                              $signed(m_axis_tdata)));
                else
                begin
                    want = expected_maxima.pop_front();
                    checked++;
                    if (m_axis_tdata !== want)
                        report_mismatch($sformatf("range_maximum expected %0d, got %0d",
                                                  $signed(want), $signed(m_axis_tdata)));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                first = s_axis_tdata[IDX_W-1:0];
                last  = s_axis_tdata[2*IDX_W-1:IDX_W];
                value = s_axis_tdata[2*IDX_W +: VAL_W];
                if (s_axis_tuser[0] == CMD_QUERY)
                    expected_maxima.push_back(clipped_range_max(first, last));
                else if (first >= 1 && first <= count_in_use())
                    element_values[first] = value;
            end
            if (cfg_wr_en)
                element_count = cfg_wr_data;
        end
        mismatch_count <= errors;
        maxima_pending <= expected_maxima.size();
        maxima_checked <= checked;
    end

endmodule

[bench/tb_range_max_segment_tree_core.sv]
`timescale 1ns / 1ps

module tb_range_max_segment_tree_core
    import rmst_pkg::*;
;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_OFF_CYCLES = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [VAL_W-1:0]     m_axis_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]     cfg_wr_data = '0;

    int mismatch_count;
    int maxima_pending;
    int maxima_checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_request = 0;
    int cycle_count = 0;
    int updates_sent = 0;
    int queries_sent = 0;
    int counts_written = 0;
    int stim_count = MAX_ELEMENTS;

    int phase_counts [RANDOM_PHASES] = '{16, 1, 2047, 64, 0, 1024, 7, 300};

    range_max_segment_tree_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    range_max_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mismatch_count(mismatch_count),
        .maxima_pending(maxima_pending),
        .maxima_checked(maxima_checked)
    );

    initial
    begin
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d maxima outstanding.",
                 cycle_count, maxima_pending);
        $display("Simulation FAILED");
        $finish;
    end

    // The receiver owns its hold-off counter; a request from the stimulus loads it.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request > 0)
            begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_beat(logic cmd, logic [IDX_W-1:0] first, logic [IDX_W-1:0] last,
                             key_t value);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_DATA_W'({value, last, first});
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (cmd == CMD_QUERY)
            queries_sent++;
        else
            updates_sent++;
    endtask

    task automatic wait_for_maxima();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (maxima_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_element_count(logic [IDX_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        stim_count = (value > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(value);
        counts_written++;
    endtask

    task automatic send_random_item();
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] last;
        key_t             value;
        int               top;
        value = $urandom;
        first = IDX_W'($urandom);
        last  = IDX_W'($urandom);
        if ($urandom_range(99) < 45)
        begin
            if (stim_count > 0 && $urandom_range(99) < 85)
                first = IDX_W'($urandom_range(1, stim_count));
            case ($urandom_range(9))
                0:       value = 32'h7FFF_FFFF;
                1:       value = SIGN_BIT;
                2, 3:    value = 32'($urandom_range(0, 15) - 8);
                default: ;
            endcase
            send_beat(CMD_UPDATE, first, last, value);
        end
        else
        begin
            if (stim_count > 0 && $urandom_range(99) < 75)
            begin
                first = IDX_W'($urandom_range(1, stim_count));
                top = stim_count;
                if ($urandom_range(3) == 0 && first + 3 < stim_count)
                    top = first + 3;
                last = IDX_W'($urandom_range(first, top));
            end
            send_beat(CMD_QUERY, first, last, value);
        end
    endtask

    initial
    begin
        int items;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 69;

        send_beat(CMD_QUERY, 11'd1, 11'd1024, 32'h0);
        send_beat(CMD_UPDATE, 11'd1, 11'd0, 32'h7FFF_FFFF);
        send_beat(CMD_UPDATE, 11'd1024, 11'd2047, SIGN_BIT);
        send_beat(CMD_UPDATE, 11'd512, 11'd0, 32'hFFFF_FFFF);
        send_beat(CMD_UPDATE, 11'd0, 11'd0, 32'd5);
        send_beat(CMD_UPDATE, 11'd1025, 11'd0, 32'd99);
        send_beat(CMD_UPDATE, 11'd2047, 11'd0, 32'h1234_5678);
        send_beat(CMD_QUERY, 11'd1, 11'd1024, 32'hFFFF_FFFF);
        send_beat(CMD_QUERY, 11'd2, 11'd1024, 32'h0);
        send_beat(CMD_QUERY, 11'd1024, 11'd1024, 32'h0);
        send_beat(CMD_QUERY, 11'd0, 11'd2047, 32'h0);
        send_beat(CMD_QUERY, 11'd5, 11'd3, 32'h0);
        send_beat(CMD_QUERY, 11'd1025, 11'd2047, 32'h0);
        send_beat(CMD_QUERY, 11'd0, 11'd0, 32'h0);
        send_beat(CMD_UPDATE, 11'd1, 11'd0, 32'hFFFF_FFF9);
        send_beat(CMD_QUERY, 11'd1, 11'd1, 32'h0);

        wait_for_maxima();
        set_element_count(11'd2);
        send_beat(CMD_QUERY, 11'd1, 11'd2047, 32'h0);
        send_beat(CMD_UPDATE, 11'd3, 11'd0, 32'h7FFF_FFFF);

        wait_for_maxima();
        set_element_count(11'd0);
        send_beat(CMD_QUERY, 11'd1, 11'd1, 32'h0);
        send_beat(CMD_UPDATE, 11'd1, 11'd0, 32'd1);

        wait_for_maxima();
        set_element_count(11'd1024);
        send_beat(CMD_QUERY, 11'd3, 11'd1024, 32'h0);
        send_beat(CMD_QUERY, 11'd1, 11'd1, 32'h0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_for_maxima();
            if (phase < 3)
            begin
                send_idle_pct = 25;
                recv_idle_pct = 69;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 69;
                recv_idle_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_element_count(IDX_W'(phase_counts[phase]));
            if (phase == 6)
                hold_off_request = HOLD_OFF_CYCLES;
            items = (phase_counts[phase] <= 1) ? 60 : ITEMS_PER_PHASE;
            repeat (items) send_random_item();
        end

        wait_for_maxima();
        $display("Sent %0d updates and %0d queries across %0d element count settings,",
                 updates_sent, queries_sent, counts_written);
        $display("with both sides stalling and one long output hold-off; %0d maxima compared.",
                 maxima_checked);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
